FILE: rtl/motor_speed_pid_with_kalman_top_defines.svh
// assertion macros for the motor speed controller checker
// no dependencies; included by the checker file only
`ifndef MOTOR_SPEED_PID_WITH_KALMAN_TOP_DEFINES_SVH
`define MOTOR_SPEED_PID_WITH_KALMAN_TOP_DEFINES_SVH

// same-cycle implication
`define MSPID_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MSPID_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mspid_pkg.sv
// shared types, constants and saturation helpers for the motor speed controller
// no dependencies
`timescale 1ns / 1ps

package mspid_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int GAIN_FRAC     = 24;
	localparam int LP_POLE       = 55968;
	localparam int LP_ZERO       = 4771;
	localparam longint US_PER_MIN = 60000000;
	localparam longint US_PER_SEC = 1000000;

	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 32;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int DEN_W   = 40;
	localparam int QUO_W   = 33;

	localparam logic [31:0] SETPOINT_RST = 32'd6553600;
	localparam logic [31:0] GAIN_P_RST   = 32'd79992088;
	localparam logic [31:0] GAIN_I_RST   = 32'd1464934492;
	localparam logic [31:0] GAIN_D_RST   = 32'd59348;
	localparam logic [31:0] PNOISE_RST   = 32'd65536;
	localparam logic [31:0] MNOISE_RST   = 32'd6553600;
	localparam logic [15:0] CPR_RST      = 16'd600;
	localparam logic [31:0] VAR_RST      = 32'd65536;

	localparam logic REQ_EDGE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef enum logic [2:0] {
		REG_SETPOINT,
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_PROC_NOISE,
		REG_MEAS_NOISE,
		REG_CPR
	} reg_idx_t;

	typedef struct packed {
		logic mul_go;
		logic div_go;
	} arith_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} arith_sts_t;

	// saturate a signed value to 32 bits
	function automatic logic signed [31:0] sat32_s(input logic signed [47:0] v);
		logic signed [31:0] r;
		if (v > 48'sh0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -48'sh0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// saturate a sign and magnitude pair to 32 bits signed
	function automatic logic signed [31:0] sat32_sm(input logic neg, input logic ovf,
			input logic [47:0] mag);
		logic signed [31:0] r;
		if (!neg) begin
			r = (ovf || mag > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : mag[31:0];
		end else begin
			r = (ovf || mag > 48'h8000_0000) ? 32'sh8000_0000 : -mag[31:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/mspid_arith.sv
// shared bit-serial arithmetic unit: shift-add multiplier and restoring divider
// depends on mspid_pkg
`timescale 1ns / 1ps

module mspid_arith import mspid_pkg::*; #(
	parameter int NUM_W = 58 + FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  arith_cmd_t         cmd,
	output arith_sts_t         sts,
	input  logic [MUL_A_W-1:0] mul_a,
	input  logic [MUL_B_W-1:0] mul_b,
	input  logic [NUM_W-1:0]   div_num,
	input  logic [DEN_W-1:0]   div_den,
	output logic [PROD_W-1:0]  prod,
	output logic [QUO_W-1:0]   quo,
	output logic               quo_ovf
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV} amode_t;

	amode_t              mode_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                done_q;
	logic [MUL_A_W-1:0]  ma_q;
	logic [PROD_W-1:0]   p_q;
	logic [NUM_W-1:0]    num_q;
	logic [DEN_W-1:0]    den_q;
	logic [DEN_W:0]      rem_q;
	logic [QUO_W-1:0]    quo_q;
	logic                ovf_q;

	logic [MUL_A_W:0]    mul_sum;
	logic [DEN_W:0]      div_trial;
	logic [DEN_W:0]      div_diff;
	logic                div_ge;

	// one multiplier bit per cycle
	assign mul_sum = {1'b0, p_q[PROD_W-1:MUL_B_W]} + (p_q[0] ? {1'b0, ma_q} : '0);

	// one quotient bit per cycle
	assign div_trial = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
	assign div_ge    = div_trial >= {1'b0, den_q};
	assign div_diff  = div_trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= A_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (mode_q == A_MUL || mode_q == A_DIV) && (cnt_q == CNT_W'(1));
			case (mode_q)
				A_IDLE: begin
					if (cmd.mul_go) begin
						cnt_q  <= CNT_W'(MUL_B_W);
						mode_q <= A_MUL;
					end else if (cmd.div_go) begin
						cnt_q  <= CNT_W'(NUM_W);
						mode_q <= A_DIV;
					end
				end
				A_MUL, A_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						mode_q <= A_IDLE;
					end
				end
				default: mode_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (mode_q)
			A_IDLE: begin
				if (cmd.mul_go) begin
					ma_q <= mul_a;
					p_q  <= {{MUL_A_W{1'b0}}, mul_b};
				end else if (cmd.div_go) begin
					num_q <= div_num;
					den_q <= div_den;
					rem_q <= '0;
					quo_q <= '0;
					ovf_q <= 1'b0;
				end
			end
			A_MUL: p_q <= {mul_sum, p_q[MUL_B_W-1:1]};
			A_DIV: begin
				rem_q <= div_ge ? div_diff : div_trial;
				num_q <= {num_q[NUM_W-2:0], 1'b0};
				quo_q <= {quo_q[QUO_W-2:0], div_ge};
				ovf_q <= ovf_q | quo_q[QUO_W-1];
			end
			default: ;
		endcase
	end

	assign sts.busy = (mode_q != A_IDLE);
	assign sts.done = done_q;
	assign prod     = p_q;
	assign quo      = quo_q;
	assign quo_ovf  = ovf_q;

endmodule

FILE: rtl/motor_speed_pid_with_kalman_top.sv
// motor speed controller: position counter, speed estimate, kalman filter and pid
// depends on mspid_pkg and mspid_arith
`timescale 1ns / 1ps
// usage
//  input stream (s_*): one word per event. tuser selects the kind: encoder edge or
//  control tick. an edge moves the position count by one (up when phase b is high)
//  and gives no result.
//  a tick carries the elapsed microseconds and gives exactly one result word on
//  the output stream (m_*): direction, duty (Q1.16, saturated at 1.0) and the
//  kalman speed estimate.
//  a tick runs through one shared bit-serial unit: 11 multiplies and 4
//  divisions, plus four steps of its own that do not use the unit. s_tready is
//  low while a tick is worked on.
//  the result sits in an output register; a stalled receiver only blocks the
//  next tick at its last step; edges are still taken while no tick is in progress.
//  configuration: cfg_valid/cfg_index/cfg_data, always ready, to be written
//  between ticks by the user, which the block does not enforce; index 7 is ignored.
//  reset (arst_n low, async) loads the default gains, noise values, setpoint
//  and counts per rev, clears position and filter state, variance to 1.0.

module motor_speed_pid_with_kalman_top import mspid_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [0] phase_b, [24:1] elapsed_us, rest zero
	input  logic [0:0]  s_tuser,   // [0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [0] drive_dir, [17:1] duty, [49:18] speed_estimate
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int NUM_W = 58 + FRAC_BITS;
	localparam int ACC_W = 49;
	localparam int U_W   = 44;
	localparam int SHR   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int SHL   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

	typedef enum logic [4:0] {
		S_IDLE, S_DEN, S_A, S_RPM, S_LP1, S_LP2, S_LPRND, S_KGAIN, S_KX, S_KP,
		S_ERR, S_EUS, S_INT, S_DM, S_DD, S_UP, S_UI, S_UD, S_DONE
	} state_t;

	state_t state_q, nxt;
	logic   advance;
	logic   nxt_mul, nxt_div;

	// configuration
	logic signed [31:0] setpoint_q;
	logic [31:0]        kp_q, ki_q, kd_q, qn_q, rn_q;
	logic [15:0]        cpr_q;

	// persistent controller state
	logic [31:0]        pos_q, pos_tick_q;
	logic signed [31:0] filt_q, prev_raw_q, x_q, integ_q, prev_err_q;
	logic [31:0]        var_q;

	// per-tick working registers
	logic [31:0]        mag_q;
	logic               neg_q;
	logic [23:0]        us_q;
	logic [DEN_W-1:0]   den_q;
	logic [PROD_W-1:0]  wide_q;
	logic signed [31:0] rpm_q, e_q, d_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [31:0]        pu_q;
	logic [16:0]        k_q;
	logic signed [32:0] diff_q;
	logic signed [U_W-1:0] u_q;

	// output word
	logic               out_valid_q;
	logic               dir_q;
	logic [16:0]        duty_q;
	logic [31:0]        est_q;

	// arithmetic unit
	arith_cmd_t         cmd_q;
	arith_sts_t         sts;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [NUM_W-1:0]   div_num;
	logic [DEN_W-1:0]   div_den;
	logic [PROD_W-1:0]  prod;
	logic [QUO_W-1:0]   quo;
	logic               quo_ovf;

	// combinational helpers
	logic [31:0]        dpos;
	logic [15:0]        cpr_eff;
	logic [23:0]        us_in;
	logic [31:0]        filt_mag, e_mag, i_mag, d_mag;
	logic signed [32:0] rs, fx;
	logic [32:0]        rs_mag, fx_mag, diff_mag;
	logic [30:0]        rpm_v;
	logic signed [31:0] rpm_new;
	logic signed [ACC_W-1:0] lp_term, lp_signed;
	logic [ACC_W-1:0]   acc_mag, acc_rnd;
	logic signed [31:0] filt_new;
	logic [32:0]        pu_sum, kden;
	logic [31:0]        pu_new;
	logic [50:0]        kx_sum;
	logic signed [47:0] kx_step;
	logic signed [31:0] x_new;
	logic [49:0]        kp_sum;
	logic signed [31:0] e_new;
	logic [QUO_W-1:0]   i_quo;
	logic signed [47:0] i_step;
	logic signed [31:0] integ_new;
	logic signed [31:0] d_new;
	logic [PROD_W-1:0]  u_sum;
	logic               u_neg;
	logic signed [U_W-1:0] u_step;
	logic [U_W-1:0]     u_mag;
	logic [16:0]        duty_new;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {6'd0, est_q, duty_q, dir_q};

	assign dpos     = pos_q - pos_tick_q;
	assign cpr_eff  = (cpr_q == 16'd0) ? 16'd1 : cpr_q;
	assign us_in    = (s_tdata[24:1] == 24'd0) ? 24'd1 : s_tdata[24:1];

	assign filt_mag = filt_q[31] ? 32'(-filt_q) : filt_q;
	assign e_mag    = e_q[31] ? 32'(-e_q) : e_q;
	assign i_mag    = integ_q[31] ? 32'(-integ_q) : integ_q;
	assign d_mag    = d_q[31] ? 32'(-d_q) : d_q;
	assign rs       = 33'(rpm_q) + 33'(prev_raw_q);
	assign rs_mag   = rs[32] ? 33'(-rs) : rs;
	assign fx       = 33'(filt_q) - 33'(x_q);
	assign fx_mag   = fx[32] ? 33'(-fx) : fx;
	assign diff_mag = diff_q[32] ? 33'(-diff_q) : diff_q;

	// speed from the divider, saturated one short of the most negative value
	assign rpm_v   = (quo_ovf || quo[32:31] != 2'b00) ? '1 : quo[30:0];
	assign rpm_new = neg_q ? -$signed({1'b0, rpm_v}) : $signed({1'b0, rpm_v});

	// low-pass filter terms
	assign lp_term   = $signed({1'b0, prod[ACC_W-2:0]});
	assign lp_signed = ((state_q == S_LP1) ? filt_q[31] : rs[32]) ? -lp_term : lp_term;
	assign acc_mag   = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : acc_q;
	assign acc_rnd   = acc_mag + ACC_W'(32768);
	assign filt_new  = sat32_sm(acc_q[ACC_W-1], 1'b0, 48'(acc_rnd[ACC_W-1:16]));

	// kalman predict and gain denominator
	assign pu_sum = {1'b0, var_q} + {1'b0, qn_q};
	assign pu_new = pu_sum[32] ? '1 : pu_sum[31:0];
	assign kden   = {1'b0, pu_q} + {1'b0, rn_q};

	// kalman estimate and variance update
	assign kx_sum  = prod[50:0] + 51'd32768;
	assign kx_step = fx[32] ? -$signed({13'd0, kx_sum[50:16]}) : $signed({13'd0, kx_sum[50:16]});
	assign x_new   = sat32_s(48'(x_q) + kx_step);
	assign kp_sum  = prod[49:0] + 50'd32768;

	// pid terms; an integral step past the quotient width saturates the sum anyway
	assign e_new     = sat32_s(48'(setpoint_q) - 48'(x_q));
	assign i_quo     = quo_ovf ? {QUO_W{1'b1}} : quo;
	assign i_step    = e_q[31] ? -$signed({15'd0, i_quo}) : $signed({15'd0, i_quo});
	assign integ_new = sat32_s(48'(integ_q) + i_step);
	assign d_new     = sat32_sm(diff_q[32], quo_ovf, {15'd0, quo});

	always_comb begin
		case (state_q)
			S_UP:    u_neg = e_q[31];
			S_UI:    u_neg = integ_q[31];
			default: u_neg = d_q[31];
		endcase
	end

	assign u_sum  = prod + PROD_W'(64'd1 << (GAIN_FRAC - 1));
	assign u_step = u_neg ? -$signed({3'd0, u_sum[PROD_W-1:GAIN_FRAC]})
			: $signed({3'd0, u_sum[PROD_W-1:GAIN_FRAC]});
	assign u_mag  = u_q[U_W-1] ? U_W'(-u_q) : u_q;
	assign duty_new = (u_mag >= (U_W'(1) << FRAC_BITS)) ? 17'd65536
			: 17'((u_mag >> SHR) << SHL);

	// operands for the shared unit, picked by the step in progress
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		div_num = '0;
		div_den = '0;
		case (state_q)
			S_DEN: begin
				mul_a = MUL_A_W'(cpr_eff);
				mul_b = MUL_B_W'(us_q);
			end
			S_A: begin
				mul_a = MUL_A_W'(US_PER_MIN);
				mul_b = mag_q;
			end
			S_RPM: begin
				div_num = (NUM_W'(wide_q[56:0]) << FRAC_BITS) + NUM_W'(den_q[DEN_W-1:1]);
				div_den = den_q;
			end
			S_LP1: begin
				mul_a = MUL_A_W'(LP_POLE);
				mul_b = filt_mag;
			end
			S_LP2: begin
				mul_a = rs_mag;
				mul_b = MUL_B_W'(LP_ZERO);
			end
			S_KGAIN: begin
				div_num = NUM_W'({pu_q, 16'd0});
				div_den = DEN_W'(kden);
			end
			S_KX: begin
				mul_a = fx_mag;
				mul_b = MUL_B_W'(k_q);
			end
			S_KP: begin
				mul_a = MUL_A_W'(18'd65536 - {1'b0, k_q});
				mul_b = pu_q;
			end
			S_EUS: begin
				mul_a = MUL_A_W'(e_mag);
				mul_b = MUL_B_W'(us_q);
			end
			S_INT: begin
				div_num = NUM_W'(wide_q) + NUM_W'(US_PER_SEC / 2);
				div_den = DEN_W'(US_PER_SEC);
			end
			S_DM: begin
				mul_a = diff_mag;
				mul_b = MUL_B_W'(US_PER_SEC);
			end
			S_DD: begin
				div_num = NUM_W'(wide_q) + NUM_W'(us_q[23:1]);
				div_den = DEN_W'(us_q);
			end
			S_UP: begin
				mul_a = MUL_A_W'(e_mag);
				mul_b = kp_q;
			end
			S_UI: begin
				mul_a = MUL_A_W'(i_mag);
				mul_b = ki_q;
			end
			S_UD: begin
				mul_a = MUL_A_W'(d_mag);
				mul_b = kd_q;
			end
			default: ;
		endcase
	end

	// sequencing of the tick
	always_comb begin
		advance = sts.done;
		nxt     = state_q;
		case (state_q)
			S_IDLE: begin
				advance = s_tvalid && (s_tuser[0] == REQ_TICK);
				nxt     = S_DEN;
			end
			S_DEN:   nxt = S_A;
			S_A:     nxt = S_RPM;
			S_RPM:   nxt = S_LP1;
			S_LP1:   nxt = S_LP2;
			S_LP2:   nxt = S_LPRND;
			S_LPRND: begin
				advance = 1'b1;
				nxt     = S_KGAIN;
			end
			S_KGAIN: nxt = S_KX;
			S_KX:    nxt = S_KP;
			S_KP:    nxt = S_ERR;
			S_ERR: begin
				advance = 1'b1;
				nxt     = S_EUS;
			end
			S_EUS:   nxt = S_INT;
			S_INT:   nxt = S_DM;
			S_DM:    nxt = S_DD;
			S_DD:    nxt = S_UP;
			S_UP:    nxt = S_UI;
			S_UI:    nxt = S_UD;
			S_UD:    nxt = S_DONE;
			S_DONE: begin
				advance = !out_valid_q || m_tready;
				nxt     = S_IDLE;
			end
			default: begin
				advance = 1'b1;
				nxt     = S_IDLE;
			end
		endcase
	end

	always_comb begin
		case (nxt)
			S_DEN, S_A, S_LP1, S_LP2, S_KX, S_KP, S_EUS, S_DM, S_UP, S_UI, S_UD: begin
				nxt_mul = 1'b1;
				nxt_div = 1'b0;
			end
			S_RPM, S_KGAIN, S_INT, S_DD: begin
				nxt_mul = 1'b0;
				nxt_div = 1'b1;
			end
			default: begin
				nxt_mul = 1'b0;
				nxt_div = 1'b0;
			end
		endcase
	end

	// state, handshake and everything that reset must set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			out_valid_q <= 1'b0;
			setpoint_q  <= SETPOINT_RST;
			kp_q        <= GAIN_P_RST;
			ki_q        <= GAIN_I_RST;
			kd_q        <= GAIN_D_RST;
			qn_q        <= PNOISE_RST;
			rn_q        <= MNOISE_RST;
			cpr_q       <= CPR_RST;
			pos_q       <= '0;
			pos_tick_q  <= '0;
			filt_q      <= '0;
			prev_raw_q  <= '0;
			x_q         <= '0;
			var_q       <= VAR_RST;
			integ_q     <= '0;
			prev_err_q  <= '0;
		end else begin
			cmd_q <= '{mul_go: advance && nxt_mul, div_go: advance && nxt_div};
			if (cfg_valid) begin
				case (reg_idx_t'(cfg_index))
					REG_SETPOINT:   setpoint_q <= cfg_data;
					REG_GAIN_P:     kp_q       <= cfg_data;
					REG_GAIN_I:     ki_q       <= cfg_data;
					REG_GAIN_D:     kd_q       <= cfg_data;
					REG_PROC_NOISE: qn_q       <= cfg_data;
					REG_MEAS_NOISE: rn_q       <= cfg_data;
					REG_CPR:        cpr_q      <= cfg_data[15:0];
					default: ;
				endcase
			end
			// a new word loads as the old one leaves
			if (state_q == S_DONE && advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				state_q <= nxt;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tuser[0] == REQ_EDGE) begin
						pos_q <= s_tdata[0] ? pos_q + 32'd1 : pos_q - 32'd1;
					end else if (s_tvalid) begin
						pos_tick_q <= pos_q;
					end
				end
				S_LP2:   if (sts.done) prev_raw_q <= rpm_q;
				S_LPRND: filt_q <= filt_new;
				S_KX:    if (sts.done) x_q <= x_new;
				S_KP:    if (sts.done) var_q <= kp_sum[47:16];
				S_INT: begin
					if (sts.done) begin
						integ_q    <= integ_new;
						prev_err_q <= e_q;
					end
				end
				default: ;
			endcase
		end
	end

	// working registers of the tick and the output word
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_tvalid && s_tuser[0] == REQ_TICK) begin
					neg_q <= dpos[31];
					mag_q <= dpos[31] ? 32'(-dpos) : dpos;
					us_q  <= us_in;
				end
			end
			S_DEN:   if (sts.done) den_q <= prod[DEN_W-1:0];
			S_A:     if (sts.done) wide_q <= prod;
			S_RPM:   if (sts.done) rpm_q <= rpm_new;
			S_LP1:   if (sts.done) acc_q <= lp_signed;
			S_LP2:   if (sts.done) acc_q <= acc_q + lp_signed;
			S_LPRND: pu_q <= pu_new;
			S_KGAIN: if (sts.done) k_q <= (kden == 33'd0) ? 17'd0 : quo[16:0];
			S_ERR:   e_q <= e_new;
			S_EUS:   if (sts.done) wide_q <= prod;
			S_INT:   if (sts.done) diff_q <= 33'(e_q) - 33'(prev_err_q);
			S_DM:    if (sts.done) wide_q <= prod;
			S_DD: begin
				if (sts.done) begin
					d_q <= d_new;
					u_q <= '0;
				end
			end
			S_UP, S_UI, S_UD: if (sts.done) u_q <= u_q + u_step;
			S_DONE: begin
				if (advance) begin
					dir_q  <= !u_q[U_W-1];
					duty_q <= duty_new;
					est_q  <= x_q;
				end
			end
			default: ;
		endcase
	end

	mspid_arith #(
		.NUM_W(NUM_W)
	) u_arith (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_q),
		.sts     (sts),
		.mul_a   (mul_a),
		.mul_b   (mul_b),
		.div_num (div_num),
		.div_den (div_den),
		.prod    (prod),
		.quo     (quo),
		.quo_ovf (quo_ovf)
	);

endmodule

FILE: rtl/mspid_checker.sv
// port-level checks for the motor speed controller, bound to the top level
// depends on mspid_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "motor_speed_pid_with_kalman_top_defines.svh"

module mspid_checker import mspid_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);

	// a stalled result word stays
	`MSPID_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result word dropped while stalled")
	`MSPID_ASSERT_NXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata), "result word changed while stalled")
	// duty never goes past full scale
	`MSPID_ASSERT_IMP(a_duty_max, clk, arst_n, m_tvalid, m_tdata[17:1] <= 17'd65536, "duty above 1.0")
	// an encoder edge makes no result
	`MSPID_ASSERT_NXT(a_edge_silent, clk, arst_n, s_tvalid && s_tready && s_tuser[0] == REQ_EDGE && !m_tvalid, !m_tvalid, "result after an edge word")
	// a tick occupies the block
	`MSPID_ASSERT_NXT(a_tick_busy, clk, arst_n, s_tvalid && s_tready && s_tuser[0] == REQ_TICK, !s_tready, "input taken during a tick")

endmodule

bind motor_speed_pid_with_kalman_top mspid_checker u_mspid_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: verif/motor_speed_pid_with_kalman_checker.sv
// scoreboard for the motor speed controller: predicts every tick result and compares
// depends on mspid_pkg; instantiated by verif/testbench.sv
`timescale 1ns / 1ps

module motor_speed_pid_with_kalman_checker import mspid_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          ticks_seen,
	output int          edges_seen
);

	typedef struct {
		logic        dir;
		logic [16:0] duty;
		logic [31:0] est;
	} drive_cmd_t;

	drive_cmd_t cmd_q[$];

	// register copies
	longint sp, kp, ki, kd, qn, rn, cpr;
	// controller state
	logic [31:0] pos, pos_tick;
	longint filt, prev_rpm, est, var_p, integ, prev_err;

	function automatic longint round_div(input longint num, input longint den);
		longint mag, q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic longint clip32(input longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// counts over elapsed time to rpm in Q16.16, saturating
	function automatic longint counts_to_rpm(input longint dpos, input longint us,
			input longint cpr_v);
		longint mag, den, a, q, r, frac, v;
		mag = (dpos < 0) ? -dpos : dpos;
		den = us * cpr_v;
		a = mag * US_PER_MIN;
		q = a / den;
		r = a % den;
		frac = ((r << 16) + den / 2) / den;
		if (q >= (64'sd1 << 15)) begin
			v = 64'sd2147483647;
		end else begin
			v = (q << 16) + frac;
			if (v > 64'sd2147483647) v = 64'sd2147483647;
		end
		return (dpos < 0) ? -v : v;
	endfunction

	task automatic predict_tick(input logic [23:0] us_in);
		longint us, cpv, dpos, rpm, pu, kden, k, e, d, u, umag;
		drive_cmd_t c;
		us = (us_in == 0) ? 1 : longint'(us_in);
		cpv = (cpr == 0) ? 1 : cpr;
		dpos = longint'($signed(pos - pos_tick));
		pos_tick = pos;
		rpm = counts_to_rpm(dpos, us, cpv);
		filt = clip32(round_div(LP_POLE * filt + LP_ZERO * (rpm + prev_rpm), 65536));
		prev_rpm = rpm;
		pu = var_p + qn;
		if (pu > 64'sd4294967295) pu = 64'sd4294967295;
		kden = pu + rn;
		k = (kden != 0) ? (pu << 16) / kden : 0;
		est = clip32(est + round_div(k * (filt - est), 65536));
		var_p = round_div((65536 - k) * pu, 65536) & 64'hFFFF_FFFF;
		e = clip32(sp - est);
		integ = clip32(integ + round_div(e * us, US_PER_SEC));
		d = clip32(round_div((e - prev_err) * US_PER_SEC, us));
		prev_err = e;
		u = round_div(kp * e, 64'sd1 << GAIN_FRAC) + round_div(ki * integ, 64'sd1 << GAIN_FRAC)
			+ round_div(kd * d, 64'sd1 << GAIN_FRAC);
		umag = (u < 0) ? -u : u;
		c.dir = (u >= 0);
		c.duty = (umag >= 65536) ? 17'd65536 : umag[16:0];
		c.est = est[31:0];
		cmd_q.push_back(c);
	endtask

	assign pending = cmd_q.size();

	always @(posedge clk or negedge arst_n) begin
		drive_cmd_t want;
		if (!arst_n) begin
			sp = longint'($signed(SETPOINT_RST));
			kp = GAIN_P_RST; ki = GAIN_I_RST; kd = GAIN_D_RST;
			qn = PNOISE_RST; rn = MNOISE_RST; cpr = CPR_RST;
			pos = 0; pos_tick = 0; filt = 0; prev_rpm = 0; est = 0;
			var_p = VAR_RST; integ = 0; prev_err = 0;
			cmd_q.delete();
			errors <= 0; ticks_seen <= 0; edges_seen <= 0;
		end else begin
			// result word first: a tick accepted now cannot answer in the same cycle
			if (m_tvalid && m_tready) begin
				if (cmd_q.size() == 0) begin
					if (errors < 10) $display("%t: result word with nothing expected: %h",
						$realtime, m_tdata);
					errors <= errors + 1;
				end else begin
					want = cmd_q.pop_front();
					if (m_tdata[0] !== want.dir || m_tdata[17:1] !== want.duty
							|| m_tdata[49:18] !== want.est) begin
						if (errors < 10) $display(
							"%t: mismatch dir %b/%b duty %0d/%0d est %0d/%0d (exp/got)",
							$realtime, want.dir, m_tdata[0], want.duty, m_tdata[17:1],
							$signed(want.est), $signed(m_tdata[49:18]));
						errors <= errors + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_SETPOINT:   sp = longint'($signed(cfg_data));
					REG_GAIN_P:     kp = cfg_data;
					REG_GAIN_I:     ki = cfg_data;
					REG_GAIN_D:     kd = cfg_data;
					REG_PROC_NOISE: qn = cfg_data;
					REG_MEAS_NOISE: rn = cfg_data;
					REG_CPR:        cpr = cfg_data[15:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == REQ_TICK) begin
					predict_tick(s_tdata[24:1]);
					ticks_seen <= ticks_seen + 1;
				end else begin
					pos = s_tdata[0] ? pos + 32'd1 : pos - 32'd1;
					edges_seen <= edges_seen + 1;
				end
			end
		end
	end

endmodule

FILE: verif/testbench.sv
// stimulus and verdict for the motor speed controller
// depends on mspid_pkg, motor_speed_pid_with_kalman_top and the checker module
`timescale 1ns / 1ps

module testbench;
	import mspid_pkg::*;

	localparam int WATCHDOG = 20000;   // idle cycles
	localparam int DRAIN_WAIT = 800;   // one tick of latency and some margin

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;        // [0] phase_b, [24:1] elapsed_us
	logic [0:0]  s_tuser = '0;        // [0] req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;             // [0] drive_dir, [17:1] duty, [49:18] speed_estimate
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	int errors, pending, ticks_seen, edges_seen;
	int send_idle_pct = 0;
	int stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	logic s_took = 1'b0, cfg_took = 1'b0;
	int quiet = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	motor_speed_pid_with_kalman_top dut (.*);

	motor_speed_pid_with_kalman_checker chk (.*);

	// handshake flags, registered for the drivers to read
	always @(posedge clk) begin
		s_took <= s_tvalid && s_tready;
		cfg_took <= cfg_valid && cfg_ready;
	end

	// watchdog: cycles with no word moving on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("timeout after %0d quiet cycles", quiet);
			$display("testbench NOT OK");
			$finish;
		end
	end

	// receiver: random stalls, or one long hold-off when asked
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				m_tready = 1'b0;
				repeat (3000) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				m_tready = ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// one input word; tuser picks edge or tick, bits above elapsed_us are zero
	task automatic send_word(input logic kind, input logic pb, input logic [23:0] us);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = kind;
		s_tdata = {7'd0, us, pb};
		do @(negedge clk); while (!s_took);
		s_tvalid = 1'b0;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(negedge clk); while (!cfg_took);
		cfg_valid = 1'b0;
	endtask

	// sender pause: every expected result in, then let a trailing edge settle
	task automatic wait_idle();
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic load_regs(input logic [31:0] spv, input logic [31:0] p,
			input logic [31:0] i, input logic [31:0] d, input logic [31:0] q,
			input logic [31:0] r, input logic [15:0] c);
		wait_idle();
		write_reg(REG_SETPOINT, spv);
		write_reg(REG_GAIN_P, p);
		write_reg(REG_GAIN_I, i);
		write_reg(REG_GAIN_D, d);
		write_reg(REG_PROC_NOISE, q);
		write_reg(REG_MEAS_NOISE, r);
		write_reg(REG_CPR, c);
	endtask

	// a burst of encoder edges, mostly one direction, then a tick
	task automatic send_burst(input int n_items);
		int n, k;
		logic dir;
		logic [23:0] us;
		n = $urandom_range(0, n_items);
		dir = 1'($urandom_range(1));
		for (k = 0; k < n; k++)
			send_word(REQ_EDGE, ($urandom_range(9) == 0) ? !dir : dir, 24'($urandom));
		case ($urandom_range(9))
			0: us = 24'($urandom);
			1: us = 24'($urandom_range(0, 3));
			2: us = 24'hFFFFFF - 24'($urandom_range(0, 3));
			default: us = 24'($urandom_range(200, 5000));
		endcase
		send_word(REQ_TICK, 1'($urandom_range(1)), us);
	endtask

	task automatic random_phase(input int idle, input int stall, input int n_words,
			input bit pressure);
		int start;
		send_idle_pct = idle;
		stall_pct = stall;
		start = ticks_seen + edges_seen;
		while (ticks_seen + edges_seen - start < n_words) begin
			if (pressure && ticks_seen + edges_seen - start >= n_words / 2) begin
				hold_req = 1'b1;
				pressure = 0;
			end
			send_burst(8);
		end
	endtask

	initial begin
		int k;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: defaults, up and down edges, zero, small and largest elapsed time
		send_word(REQ_TICK, 1'b0, 24'd1000);
		send_word(REQ_EDGE, 1'b1, 24'hFFFFFF);
		send_word(REQ_EDGE, 1'b1, 24'd0);
		send_word(REQ_EDGE, 1'b0, 24'h555555);
		send_word(REQ_TICK, 1'b1, 24'd0);
		send_word(REQ_TICK, 1'b0, 24'hFFFFFF);
		for (k = 0; k < 5; k++) send_word(REQ_EDGE, 1'b0, 24'hAAAAAA);
		send_word(REQ_TICK, 1'b1, 24'd1);
		// zero counts per rev and noise values, largest setpoint and gains, saturating speed
		load_regs(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'd0, 32'd0, 16'd0);
		for (k = 0; k < 4; k++) send_word(REQ_EDGE, 1'b1, 24'd7);
		send_word(REQ_TICK, 1'b0, 24'd1);
		send_word(REQ_TICK, 1'b0, 24'd2);
		// both noise values at full scale; lowest setpoint, zero gains
		load_regs(32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_word(REQ_TICK, 1'b1, 24'd1);
		for (k = 0; k < 3; k++) send_word(REQ_EDGE, 1'b0, 24'd0);
		send_word(REQ_TICK, 1'b0, 24'hFFFFFF);

		// random, with the four idling patterns and a few register settings
		load_regs(SETPOINT_RST, GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, PNOISE_RST,
			MNOISE_RST, 16'd20);
		random_phase(0, 0, 130, 0);
		load_regs($urandom, $urandom_range(0, 32'h0200_0000), $urandom_range(0, 32'h0100_0000),
			$urandom, $urandom, $urandom, 16'($urandom_range(1, 64)));
		random_phase(56, 0, 130, 1);
		load_regs(-32'sd6553600, 32'h0080_0000, 32'h0001_0000, 32'd100, 32'd0, 32'd655360,
			16'd1);
		random_phase(0, 56, 130, 0);
		load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 16'($urandom));
		random_phase(18, 18, 130, 0);

		wait_idle();
		repeat (DRAIN_WAIT) @(negedge clk);
		$display("covered %0d encoder edges and %0d control ticks, %0d mismatches",
			edges_seen, ticks_seen, errors);
		$display("register sets from zero to full scale, with sender and receiver idling");
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/mspid_pkg.sv
rtl/mspid_arith.sv
rtl/motor_speed_pid_with_kalman_top.sv
rtl/mspid_checker.sv
verif/motor_speed_pid_with_kalman_checker.sv
verif/testbench.sv
